>>> sv/ewalu_pkg.sv
// Shared types, constants and arithmetic step functions for the elementwise ALU.
// No dependencies; the core and the testbench import this package.
`default_nettype none
package ewalu_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int QW          = 32 + FRAC_BITS;
    localparam int DIV_STAGES  = (QW + 1) / 2;
    localparam int DQW         = 2 * DIV_STAGES;
    localparam int SQ_STAGES   = 16;
    localparam int ADDR_W      = 4;

    localparam logic [63:0] ONE64  = 64'(1) << FRAC_BITS;
    localparam logic [63:0] HALF64 = ONE64 >> 1;
    localparam logic [31:0] ONE32  = ONE64[31:0];
    localparam logic [31:0] POS_MAX = 32'h7fff_ffff;
    localparam logic [31:0] NEG_MAX = 32'h8000_0000;

    typedef enum logic [3:0] {
        OP_ADD     = 4'd0,
        OP_SUB     = 4'd1,
        OP_MUL     = 4'd2,
        OP_DIV     = 4'd3,
        OP_ABSDIFF = 4'd4,
        OP_HYPOT   = 4'd5,
        OP_MIN     = 4'd6,
        OP_MAX     = 4'd7,
        OP_LT      = 4'd8,
        OP_GT      = 4'd9,
        OP_EQ      = 4'd10
    } t_op;

    typedef enum logic [1:0] {
        REG_OPERATION = 2'd0,
        REG_LEFT_SEL  = 2'd1,
        REG_LEFT_CONST = 2'd2
    } t_reg;

    typedef struct packed {
        logic        flag;
        logic [31:0] res;
    } t_sat;

    typedef struct packed {
        logic [31:0]    rem;
        logic [DQW-1:0] dq;
        logic [31:0]    d;
    } t_div;

    typedef struct packed {
        logic [32:0] rem;
        logic [31:0] root;
        logic [63:0] n;
    } t_sqrt;

    function automatic t_sat sat_mag(input logic neg, input logic [63:0] mag);
        t_sat s;
        s.flag = 1'b0;
        if (neg) begin
            if (mag > 64'h8000_0000) begin
                s.flag = 1'b1;
                s.res  = NEG_MAX;
            end else begin
                s.res = 32'(~mag + 64'd1);
            end
        end else begin
            if (mag > 64'h7fff_ffff) begin
                s.flag = 1'b1;
                s.res  = POS_MAX;
            end else begin
                s.res = mag[31:0];
            end
        end
        return s;
    endfunction

    function automatic logic [32:0] mag33(input logic [32:0] v);
        return v[32] ? (~v + 33'd1) : v;
    endfunction

    function automatic t_div div_step(input t_div s);
        logic [32:0] t;
        logic        ge;
        t_div        o;
        t  = {s.rem, s.dq[DQW-1]};
        ge = t >= {1'b0, s.d};
        o.d   = s.d;
        o.rem = ge ? 32'(t - {1'b0, s.d}) : t[31:0];
        o.dq  = {s.dq[DQW-2:0], ge};
        return o;
    endfunction

    function automatic t_sqrt sqrt_step(input t_sqrt s);
        logic [34:0] rem2;
        logic [34:0] trial;
        logic        ge;
        t_sqrt       o;
        rem2  = {s.rem[32:0], s.n[63:62]};
        trial = {1'b0, s.root, 2'b01};
        ge    = rem2 >= trial;
        o.rem  = ge ? 33'(rem2 - trial) : rem2[32:0];
        o.root = {s.root[30:0], ge};
        o.n    = {s.n[61:0], 2'b00};
        return o;
    endfunction

endpackage
`default_nettype wire

>>> sv/ewalu_in_if.sv
// Input channel carrying one left and right sample pair per beat.
// No dependencies.
`default_nettype none
interface ewalu_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] left_value;
    logic [31:0] right_value;
    modport source (output valid, output left_value, output right_value, input ready);
    modport sink (input valid, input left_value, input right_value, output ready);
endinterface
`default_nettype wire

>>> sv/ewalu_out_if.sv
// Output channel carrying one result and its saturation flag per beat.
// No dependencies.
`default_nettype none
interface ewalu_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result;
    logic        saturated;
    modport source (output valid, output result, output saturated, input ready);
    modport sink (input valid, input result, input saturated, output ready);
endinterface
`default_nettype wire

>>> sv/elementwise_binary_alu_core.sv
// Elementwise ALU on Q16.16 samples: one beat per cycle while the output is not stalled.
// The pipeline length is set by the radix-4 quotient pipeline, two quotient bits per stage.
// All stages advance together whenever the output register is empty or taken.
// Synchronous active-low reset clears all valid bits and the configuration registers.
// Depends on ewalu_pkg, ewalu_in_if and ewalu_out_if.
`default_nettype none
module elementwise_binary_alu_core
    import ewalu_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    ewalu_in_if.sink               in_ch,
    ewalu_out_if.source            out_ch,
    input  wire logic              i_psel,
    input  wire logic              i_penable,
    input  wire logic              i_pwrite,
    input  wire logic [ADDR_W-1:0] i_paddr,
    input  wire logic [31:0]       i_pwdata,
    output logic [31:0]            o_prdata,
    output logic                   o_pready
);

    typedef struct packed {
        logic [3:0]  op;
        logic [31:0] l;
        logic [31:0] r;
    } t_s1;

    typedef struct packed {
        logic [3:0]  op;
        t_sat        sat;
        logic        lneg;
        logic        qneg;
        logic [31:0] ml;
        logic [31:0] mr;
        logic [63:0] p1;
        logic [63:0] p2;
    } t_s2;

    typedef struct packed {
        logic [3:0] op;
        t_sat       sat;
        logic       lneg;
        logic       qneg;
        logic       dz;
        t_div       dv;
        t_sqrt      sq;
    } t_it;

    logic [3:0]  r_op;
    logic        r_lsel;
    logic [31:0] r_lconst;

    logic                r_v1, r_v2, r_vo;
    logic [DIV_STAGES:0] r_vit;
    t_s1                 r_s1, n_s1;
    t_s2                 r_s2, n_s2;
    t_it                 r_it [DIV_STAGES+1];
    t_it                 n_it [DIV_STAGES+1];
    t_sat                r_out, n_out;
    logic                en;
    logic                cfg_wr;
    t_reg                cfg_idx;

    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite;
    assign cfg_idx  = t_reg'(i_paddr[3:2]);

    always_comb begin
        o_prdata = '0;
        unique case (cfg_idx)
            REG_OPERATION:  o_prdata = {28'd0, r_op};
            REG_LEFT_SEL:   o_prdata = {31'd0, r_lsel};
            REG_LEFT_CONST: o_prdata = r_lconst;
            default:        o_prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op     <= '0;
            r_lsel   <= 1'b0;
            r_lconst <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_OPERATION:  r_op     <= i_pwdata[3:0];
                REG_LEFT_SEL:   r_lsel   <= i_pwdata[0];
                REG_LEFT_CONST: r_lconst <= i_pwdata;
                default: ;
            endcase
        end
    end

    assign en          = !r_vo || out_ch.ready;
    assign in_ch.ready = en;

    always_comb begin
        n_s1.op = r_op;
        n_s1.l  = r_lsel ? r_lconst : in_ch.left_value;
        n_s1.r  = in_ch.right_value;
    end

    always_comb begin
        logic [32:0] sum, dif;
        logic        lt, gt, eq;
        sum = {r_s1.l[31], r_s1.l} + {r_s1.r[31], r_s1.r};
        dif = {r_s1.l[31], r_s1.l} - {r_s1.r[31], r_s1.r};
        lt  = $signed(r_s1.l) < $signed(r_s1.r);
        gt  = $signed(r_s1.l) > $signed(r_s1.r);
        eq  = r_s1.l == r_s1.r;
        n_s2.op   = r_s1.op;
        n_s2.lneg = r_s1.l[31];
        n_s2.qneg = r_s1.l[31] ^ r_s1.r[31];
        n_s2.ml   = r_s1.l[31] ? (~r_s1.l + 32'd1) : r_s1.l;
        n_s2.mr   = r_s1.r[31] ? (~r_s1.r + 32'd1) : r_s1.r;
        n_s2.p1   = 64'(n_s2.ml) * 64'((t_op'(r_s1.op) == OP_MUL) ? n_s2.mr : n_s2.ml);
        n_s2.p2   = 64'(n_s2.mr) * 64'(n_s2.mr);
        n_s2.sat  = '0;
        case (t_op'(r_s1.op))
            OP_ADD:     n_s2.sat = sat_mag(sum[32], 64'(mag33(sum)));
            OP_SUB:     n_s2.sat = sat_mag(dif[32], 64'(mag33(dif)));
            OP_ABSDIFF: n_s2.sat = sat_mag(1'b0, 64'(mag33(dif)));
            OP_MIN:     n_s2.sat.res = lt ? r_s1.l : r_s1.r;
            OP_MAX:     n_s2.sat.res = gt ? r_s1.l : r_s1.r;
            OP_LT:      n_s2.sat.res = lt ? ONE32 : 32'd0;
            OP_GT:      n_s2.sat.res = gt ? ONE32 : 32'd0;
            OP_EQ:      n_s2.sat.res = eq ? ONE32 : 32'd0;
            default:    n_s2.sat = '0;
        endcase
    end

    always_comb begin
        n_it[0].op   = r_s2.op;
        n_it[0].lneg = r_s2.lneg;
        n_it[0].qneg = r_s2.qneg;
        n_it[0].dz   = r_s2.mr == 32'd0;
        n_it[0].sat  = r_s2.sat;
        if (t_op'(r_s2.op) == OP_MUL) begin
            n_it[0].sat = sat_mag(r_s2.qneg, (r_s2.p1 + HALF64) >> FRAC_BITS);
        end
        n_it[0].dv.rem = '0;
        n_it[0].dv.d   = r_s2.mr;
        n_it[0].dv.dq  = DQW'(r_s2.ml) << FRAC_BITS;
        n_it[0].sq.rem  = '0;
        n_it[0].sq.root = '0;
        n_it[0].sq.n    = r_s2.p1 + r_s2.p2;
        for (int k = 0; k < DIV_STAGES; k++) begin
            n_it[k+1] = r_it[k];
            for (int j = 0; j < 2; j++) begin
                n_it[k+1].dv = div_step(n_it[k+1].dv);
                if (k < SQ_STAGES) begin
                    n_it[k+1].sq = sqrt_step(n_it[k+1].sq);
                end
            end
        end
    end

    always_comb begin
        t_it f;
        f     = r_it[DIV_STAGES];
        n_out = f.sat;
        if (t_op'(f.op) == OP_DIV) begin
            if (f.dz) begin
                n_out.flag = 1'b1;
                n_out.res  = f.lneg ? NEG_MAX : POS_MAX;
            end else begin
                n_out = sat_mag(f.qneg, 64'(f.dv.dq));
            end
        end else if (t_op'(f.op) == OP_HYPOT) begin
            n_out = sat_mag(1'b0, 64'(f.sq.root));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_vit <= '0;
            r_vo  <= 1'b0;
        end else if (en) begin
            r_v1  <= in_ch.valid;
            r_v2  <= r_v1;
            r_vit <= {r_vit[DIV_STAGES-1:0], r_v2};
            r_vo  <= r_vit[DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1  <= n_s1;
            r_s2  <= n_s2;
            r_it  <= n_it;
            r_out <= n_out;
        end
    end

    assign out_ch.valid     = r_vo;
    assign out_ch.result    = r_out.res;
    assign out_ch.saturated = r_out.flag;

endmodule
`default_nettype wire

>>> sv/ewalu_checker.sv
// Port-level checks for the elementwise ALU core, attached by bind.
// Depends on elementwise_binary_alu_core.
`default_nettype none
module ewalu_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] i_result,
    input wire logic        i_saturated,
    input wire logic        i_pready
);

    a_pready: assert property (@(posedge i_clk) i_pready)
        else $error("pready dropped");

    a_reset_clear: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_saturated |-> (i_result == 32'h7fff_ffff || i_result == 32'h8000_0000))
        else $error("saturated beat not at a bound");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled while output empty");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_result) && $stable(i_saturated))
        else $error("stalled beat changed");

endmodule

bind elementwise_binary_alu_core ewalu_checker u_ewalu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (in_ch.ready),
    .i_out_valid (out_ch.valid),
    .i_out_ready (out_ch.ready),
    .i_result    (out_ch.result),
    .i_saturated (out_ch.saturated),
    .i_pready    (o_pready)
);
`default_nettype wire

>>> sim/elementwise_binary_alu_core_tb.sv
// Self-checking testbench for elementwise_binary_alu_core: directed table, then random
// pairs through a predictor, with random source bursts and sink stalls.
// Depends on ewalu_pkg, ewalu_in_if, ewalu_out_if and the core RTL.
`default_nettype none
module elementwise_binary_alu_core_tb;
    import ewalu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG = 5000;
    localparam int N_RANDOM = 2000;

    typedef struct packed {
        logic [31:0] result;
        logic        saturated;
    } t_alu_out;

    typedef struct {
        logic [31:0] left;
        logic [31:0] right;
        logic        known;
        logic [31:0] result;
        logic        saturated;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_psel = 1'b0;
    logic i_penable = 1'b0;
    logic i_pwrite = 1'b0;
    logic [ADDR_W-1:0] i_paddr = '0;
    logic [31:0] i_pwdata = '0;
    logic [31:0] o_prdata;
    logic o_pready;

    ewalu_in_if in_ch ();
    ewalu_out_if out_ch ();

    elementwise_binary_alu_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
        .i_psel(i_psel), .i_penable(i_penable), .i_pwrite(i_pwrite), .i_paddr(i_paddr),
        .i_pwdata(i_pwdata), .o_prdata(o_prdata), .o_pready(o_pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    logic [3:0]  cfg_op;
    logic        cfg_use_const;
    logic [31:0] cfg_const;
    t_alu_out    pending_results[$];
    int          n_errors = 0;
    int          idle_cycles = 0;
    int          stall_mode = 0;

    function automatic t_alu_out clip(input logic neg, input logic [63:0] mag);
        t_alu_out o;
        o.saturated = 1'b0;
        if (neg) begin
            if (mag > 64'h8000_0000) begin
                o.saturated = 1'b1;
                mag = 64'h8000_0000;
            end
            o.result = 32'(-mag);
        end else begin
            if (mag > 64'h7fff_ffff) begin
                o.saturated = 1'b1;
                mag = 64'h7fff_ffff;
            end
            o.result = mag[31:0];
        end
        return o;
    endfunction

    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_alu_out alu_predict(input logic [31:0] lv, input logic [31:0] rv);
        logic signed [63:0] l;
        logic signed [63:0] r;
        logic signed [63:0] p;
        logic [63:0] m;
        logic [63:0] ml;
        logic [63:0] mr;
        t_alu_out o;
        l = 64'(signed'(cfg_use_const ? cfg_const : lv));
        r = 64'(signed'(rv));
        o = '0;
        case (cfg_op)
            OP_ADD: o = clip(l + r < 0, abs64(l + r));
            OP_SUB: o = clip(l - r < 0, abs64(l - r));
            OP_MUL: begin
                p = l * r;
                m = (abs64(p) + HALF64) >> FRAC_BITS;
                o = clip(p < 0, m);
            end
            OP_DIV: begin
                if (r == 0) begin
                    o.saturated = 1'b1;
                    o.result = l < 0 ? NEG_MAX : POS_MAX;
                end else begin
                    o = clip((l < 0) != (r < 0), (abs64(l) << FRAC_BITS) / abs64(r));
                end
            end
            OP_ABSDIFF: o = clip(1'b0, abs64(l - r));
            OP_HYPOT: begin
                ml = abs64(l);
                mr = abs64(r);
                o = clip(1'b0, int_sqrt(ml * ml + mr * mr));
            end
            OP_MIN: o.result = 32'(l < r ? l : r);
            OP_MAX: o.result = 32'(l > r ? l : r);
            OP_LT: o.result = l < r ? ONE32 : 32'd0;
            OP_GT: o.result = l > r ? ONE32 : 32'd0;
            OP_EQ: o.result = l == r ? ONE32 : 32'd0;
            default: o = '0;
        endcase
        return o;
    endfunction

    task automatic reg_write(input t_reg idx, input logic [31:0] value);
        i_psel <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite <= 1'b1;
        i_paddr <= ADDR_W'(4 * int'(idx));
        i_pwdata <= value;
        @(negedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        while (!o_pready) @(posedge i_clk);
        @(negedge i_clk);
        i_psel <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite <= 1'b0;
        case (idx)
            REG_OPERATION: cfg_op = value[3:0];
            REG_LEFT_SEL: cfg_use_const = value[0];
            default: cfg_const = value;
        endcase
        @(negedge i_clk);
    endtask

    task automatic configure(input t_op op, input logic use_const, input logic [31:0] k);
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DIV_STAGES + 8) @(negedge i_clk);
        reg_write(REG_OPERATION, 32'(op));
        reg_write(REG_LEFT_SEL, 32'(use_const));
        reg_write(REG_LEFT_CONST, k);
    endtask

    // Drives one pair at a falling edge and holds it until the beat is taken.
    task automatic send_pair(input logic [31:0] lv, input logic [31:0] rv, input logic hold);
        in_ch.valid <= 1'b1;
        in_ch.left_value <= lv;
        in_ch.right_value <= rv;
        pending_results.push_back(alu_predict(lv, rv));
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        if (!hold) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'd0;
            3: return 32'($urandom_range(0, 8)) << FRAC_BITS;
            4: return -(32'($urandom_range(0, 8)) << FRAC_BITS);
            5: return 32'(signed'(16'($urandom())));
            default: return $urandom();
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected: %h", out_ch.result);
                n_errors++;
            end else begin
                t_alu_out exp_out;
                exp_out = pending_results.pop_front();
                if (out_ch.result !== exp_out.result) begin
                    $error("result: expected %h, actual %h", exp_out.result, out_ch.result);
                    n_errors++;
                end
                if (out_ch.saturated !== exp_out.saturated) begin
                    $error("saturated: expected %b, actual %b", exp_out.saturated,
                           out_ch.saturated);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n
                || i_psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG) begin
            $display("elementwise_binary_alu_core: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= $urandom_range(0, 3) != 0;
            2: out_ch.ready <= $urandom_range(0, 1);
            default: out_ch.ready <= $urandom_range(0, 7) == 0;
        endcase
    end

    t_row directed[5] = '{
        '{32'h7fff_ffff, 32'h0000_0001, 1'b1, 32'h7fff_ffff, 1'b1},
        '{32'h8000_0000, 32'hffff_ffff, 1'b1, 32'h8000_0000, 1'b1},
        '{32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
        '{32'h0001_0000, 32'h0002_0000, 1'b1, 32'h0003_0000, 1'b0},
        '{32'h8000_0000, 32'h7fff_ffff, 1'b1, 32'hffff_ffff, 1'b0}
    };

    t_op op_list[11] = '{OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_ABSDIFF, OP_HYPOT, OP_MIN,
                         OP_MAX, OP_LT, OP_GT, OP_EQ};

    logic [31:0] edge_vals[5] = '{32'h7fff_ffff, 32'h8000_0000, 32'd0, 32'h0001_0000,
                                  32'hffff_0000};

    initial begin
        int n_sent;
        int burst;
        in_ch.valid = 1'b0;
        in_ch.left_value = '0;
        in_ch.right_value = '0;
        out_ch.ready = 1'b1;
        cfg_op = 4'(OP_ADD);
        cfg_use_const = 1'b0;
        cfg_const = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed[i]) begin
            send_pair(directed[i].left, directed[i].right, 1'b0);
            if (directed[i].known) begin
                pending_results[$].result = directed[i].result;
                pending_results[$].saturated = directed[i].saturated;
            end
        end
        configure(OP_DIV, 1'b0, 32'd0);
        send_pair(32'h0001_0000, 32'd0, 1'b0);
        pending_results[$] = '{32'h7fff_ffff, 1'b1};
        send_pair(32'hffff_0000, 32'd0, 1'b0);
        pending_results[$] = '{32'h8000_0000, 1'b1};
        send_pair(32'd0, 32'd0, 1'b0);
        pending_results[$] = '{32'h7fff_ffff, 1'b1};
        foreach (op_list[k]) begin
            configure(op_list[k], 1'b0, 32'd0);
            send_pair(edge_vals[k % 5], edge_vals[(k + 1) % 5], 1'b0);
        end
        configure(t_op'(4'd13), 1'b0, 32'd0);
        send_pair(32'h1234_5678, 32'h0001_0000, 1'b0);
        pending_results[$] = '{32'd0, 1'b0};

        n_sent = 0;
        while (n_sent < N_RANDOM) begin
            case ($urandom_range(0, 5))
                0: configure(op_list[$urandom_range(0, 10)], 1'b1, 32'h7fff_ffff);
                1: configure(op_list[$urandom_range(0, 10)], 1'b1, 32'h8000_0000);
                2: configure(op_list[$urandom_range(0, 10)], 1'b1, rand_sample());
                3: configure(t_op'(4'($urandom_range(11, 15))), 1'b0, $urandom());
                default: configure(op_list[$urandom_range(0, 10)], 1'b0, $urandom());
            endcase
            repeat ($urandom_range(1, 6)) begin
                burst = $urandom_range(1, 40);
                for (int j = 0; j < burst; j++) begin
                    send_pair(rand_sample(), rand_sample(), j != burst - 1);
                    n_sent++;
                end
                if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end
        end

        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DIV_STAGES + 8) @(negedge i_clk);
        if (n_errors == 0) begin
            $display("elementwise_binary_alu_core: match");
        end else begin
            $display("elementwise_binary_alu_core: mismatch");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> sim.f
sv/ewalu_pkg.sv
sv/ewalu_in_if.sv
sv/ewalu_out_if.sv
sv/elementwise_binary_alu_core.sv
sv/ewalu_checker.sv
sim/elementwise_binary_alu_core_tb.sv
